// File: sv/ccpi_pkg.sv
// Shared types, register map and constants for the CC/CV charge PI controller.
`default_nettype none

package ccpi_pkg;

  // Fixed field widths of the ports and registers
  localparam int ADC_W       = 12;
  localparam int GAIN_W      = 16;
  localparam int TS_W        = 24;
  localparam int DRV_W       = 32;
  localparam int IDX_W       = 4;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 72;

  // Shared multiplier operand and product widths, accumulator and coefficient widths
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 37;
  localparam int C2_W    = 18;
  localparam int KITS_W  = 17;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_CUR_KP   = 4'd0;
  localparam logic [IDX_W-1:0] REG_CUR_KI   = 4'd1;
  localparam logic [IDX_W-1:0] REG_VOLT_KP  = 4'd2;
  localparam logic [IDX_W-1:0] REG_VOLT_KI  = 4'd3;
  localparam logic [IDX_W-1:0] REG_TS       = 4'd4;
  localparam logic [IDX_W-1:0] REG_CUR_TGT  = 4'd5;
  localparam logic [IDX_W-1:0] REG_VOLT_TGT = 4'd6;
  localparam logic [IDX_W-1:0] REG_END_CUR  = 4'd7;

  // Register reset values
  localparam logic [GAIN_W-1:0] RST_CUR_KP   = 16'd8192;
  localparam logic [GAIN_W-1:0] RST_CUR_KI   = 16'd2048;
  localparam logic [GAIN_W-1:0] RST_VOLT_KP  = 16'd6554;
  localparam logic [GAIN_W-1:0] RST_VOLT_KI  = 16'd1229;
  localparam logic [TS_W-1:0]   RST_TS       = 24'd1678;
  localparam logic [ADC_W-1:0]  RST_CUR_TGT  = 12'd1024;
  localparam logic [ADC_W-1:0]  RST_VOLT_TGT = 12'd2048;
  localparam logic [ADC_W-1:0]  RST_END_CUR  = 12'd100;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CC   = 2'd1,
    PH_CV   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_KITS,
    ST_KP,
    ST_KE,
    ST_FIN,
    ST_OUT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_KITS,
    OP_KP,
    OP_KE,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    logic [GAIN_W-1:0] current_gain_p;
    logic [GAIN_W-1:0] current_gain_i;
    logic [GAIN_W-1:0] voltage_gain_p;
    logic [GAIN_W-1:0] voltage_gain_i;
    logic [TS_W-1:0]   sample_period;
    logic [ADC_W-1:0]  current_target;
    logic [ADC_W-1:0]  voltage_target;
    logic [ADC_W-1:0]  end_current;
  } cfg_t;

  typedef struct packed {
    logic   load_in;
    dp_op_t op;
    logic   sel_volt;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic v_below;
    logic i_above;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: sv/cc_cv_charge_pi_controller_core.sv
// Top level of the CC/CV charge controller with incremental PI current and voltage loops.
// out_tvalid rises as the sequencer leaves OUT: after EVAL, KITS, KP, KE and FIN when a PI
// loop runs, or straight after EVAL when the tick only changes phase or idles.
// A new request is taken only once the sequencer is back in idle, and OUT waits for a free output; one shared
// 18x25 multiplier takes Ki*Ts, Kp*e and the error-old product in turn.
// Reset (rst_n low, synchronous): phase idle, loop outputs and errors zero, registers at defaults.
`default_nettype none

module cc_cv_charge_pi_controller_core #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // tdata: [11:0] voltage_sample, [23:12] current_sample, [24] start_request
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [ccpi_pkg::IN_TDATA_W-1:0]    in_tdata,
  // tdata: [1:0] phase, [33:2] current_drive, [65:34] voltage_drive
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [ccpi_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                    out_tlast,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ccpi_pkg::IDX_W-1:0]         cfg_index,
  input  wire logic [ccpi_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ccpi_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_stat_t   stat;
  phase_t     out_phase;
  logic [DRV_W-1:0] current_drive, voltage_drive;

  ccpi_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ccpi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_start   (in_tdata[2*ADC_W]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_phase  (out_phase),
    .out_done   (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

  ccpi_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_voltage    (in_tdata[ADC_W-1:0]),
    .in_current    (in_tdata[2*ADC_W-1:ADC_W]),
    .cfg           (cfg),
    .cmd           (cmd),
    .stat          (stat),
    .current_drive (current_drive),
    .voltage_drive (voltage_drive)
  );

  assign out_tdata = {{(OUT_TDATA_W-2*DRV_W-2){1'b0}}, voltage_drive, current_drive,
                      logic'(out_phase[1]), logic'(out_phase[0])};

  // a request is worked on alone: the input closes right after it is taken
  a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a request is in flight");

  // the end-of-charge flag only comes with the idle phase
  a_done_is_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[1:0] == PH_IDLE))
    else $error("charge done reported outside idle");

  // a new result is loaded only as the sequencer returns to idle
  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result offered while sequencer busy");

endmodule

`default_nettype wire

// File: sv/ccpi_regs.sv
// Configuration register file of the charge controller.
`default_nettype none

module ccpi_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ccpi_pkg::IDX_W-1:0]      cfg_index,
  input  wire logic [ccpi_pkg::CFG_DATA_W-1:0] cfg_data,
  output ccpi_pkg::cfg_t                     cfg
);
  import ccpi_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_CUR_KP:   cfg_nxt.current_gain_p = cfg_data[GAIN_W-1:0];
        REG_CUR_KI:   cfg_nxt.current_gain_i = cfg_data[GAIN_W-1:0];
        REG_VOLT_KP:  cfg_nxt.voltage_gain_p = cfg_data[GAIN_W-1:0];
        REG_VOLT_KI:  cfg_nxt.voltage_gain_i = cfg_data[GAIN_W-1:0];
        REG_TS:       cfg_nxt.sample_period  = cfg_data[TS_W-1:0];
        REG_CUR_TGT:  cfg_nxt.current_target = cfg_data[ADC_W-1:0];
        REG_VOLT_TGT: cfg_nxt.voltage_target = cfg_data[ADC_W-1:0];
        REG_END_CUR:  cfg_nxt.end_current    = cfg_data[ADC_W-1:0];
        default:      cfg_nxt = cfg_r; // drop writes beyond the map
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.current_gain_p <= RST_CUR_KP;
      cfg_r.current_gain_i <= RST_CUR_KI;
      cfg_r.voltage_gain_p <= RST_VOLT_KP;
      cfg_r.voltage_gain_i <= RST_VOLT_KI;
      cfg_r.sample_period  <= RST_TS;
      cfg_r.current_target <= RST_CUR_TGT;
      cfg_r.voltage_target <= RST_VOLT_TGT;
      cfg_r.end_current    <= RST_END_CUR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/ccpi_ctrl.sv
// Sequencer of the charge controller: phase machine, PI step order and output handshake.
`default_nettype none

module ccpi_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic               in_start,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output ccpi_pkg::phase_t        out_phase,
  output logic                    out_done,
  output ccpi_pkg::dp_cmd_t       cmd,
  input  wire ccpi_pkg::dp_stat_t stat
);
  import ccpi_pkg::*;

  ctrl_state_t state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  phase_t      out_phase_r, out_phase_nxt;
  logic        start_r, start_nxt;
  logic        sel_volt_r, sel_volt_nxt;
  logic        done_r, done_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_done_r, out_done_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_phase  = out_phase_r;
  assign out_done   = out_done_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    start_nxt     = start_r;
    sel_volt_nxt  = sel_volt_r;
    done_nxt      = done_r;
    out_phase_nxt = out_phase_r;
    out_done_nxt  = out_done_r;
    out_valid_nxt = out_valid_r && !out_tready;

    cmd.load_in  = 1'b0;
    cmd.op       = OP_NONE;
    cmd.sel_volt = sel_volt_r;
    cmd.out_load = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          start_nxt   = in_start;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        done_nxt  = 1'b0;
        state_nxt = ST_OUT;
        unique case (phase_r)
          PH_IDLE: begin
            if (start_r) phase_nxt = PH_CC;
          end
          PH_CC: begin
            if (stat.v_below) begin
              sel_volt_nxt = 1'b0;
              state_nxt    = ST_KITS;
            end else begin
              phase_nxt = PH_CV;
            end
          end
          PH_CV: begin
            if (stat.i_above) begin
              sel_volt_nxt = 1'b1;
              state_nxt    = ST_KITS;
            end else begin
              phase_nxt = PH_IDLE;
              done_nxt  = 1'b1;
            end
          end
          default: phase_nxt = PH_IDLE; // unused code falls back to idle
        endcase
      end
      ST_KITS: begin
        cmd.op    = OP_KITS;
        state_nxt = ST_KP;
      end
      ST_KP: begin
        cmd.op    = OP_KP;
        state_nxt = ST_KE;
      end
      ST_KE: begin
        cmd.op    = OP_KE;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.op    = OP_FIN;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          out_phase_nxt = phase_r;
          out_done_nxt  = done_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_IDLE;
      start_r     <= 1'b0;
      sel_volt_r  <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_phase_r <= PH_IDLE;
      out_done_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      start_r     <= start_nxt;
      sel_volt_r  <= sel_volt_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      out_phase_r <= out_phase_nxt;
      out_done_r  <= out_done_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/ccpi_dp.sv
// Datapath of the charge controller: shared multiplier, PI accumulate and saturation.
`default_nettype none

module ccpi_dp #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [ccpi_pkg::ADC_W-1:0] in_voltage,
  input  wire logic [ccpi_pkg::ADC_W-1:0] in_current,
  input  wire ccpi_pkg::cfg_t            cfg,
  input  wire ccpi_pkg::dp_cmd_t         cmd,
  output ccpi_pkg::dp_stat_t             stat,
  output logic [ccpi_pkg::DRV_W-1:0]     current_drive,
  output logic [ccpi_pkg::DRV_W-1:0]     voltage_drive
);
  import ccpi_pkg::*;

  localparam int EW = SAMPLE_BITS + 1;
  localparam logic [KITS_W+TS_W-1:0] KITS_RND = (KITS_W + TS_W)'(1) << (TS_W - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);

  logic [SAMPLE_BITS-1:0] v_r, i_r;
  logic signed [PROD_W-1:0] p_r;
  logic signed [C2_W-1:0]   c2_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [DRV_W-1:0]  cur_out_r, volt_out_r;
  logic signed [EW-1:0]     cur_err_r, volt_err_r;
  logic [DRV_W-1:0]         cur_drive_r, volt_drive_r;

  logic [SAMPLE_BITS-1:0]   cur_tgt, volt_tgt, end_cur, tgt_sel, smp_sel;
  logic [GAIN_W-1:0]        kp_sel, ki_sel;
  logic signed [EW-1:0]     err_now, err_prev_sel;
  logic signed [DRV_W-1:0]  out_prev_sel;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0] product;
  logic [KITS_W+TS_W-1:0]   kits_sum;
  logic [KITS_W-1:0]        kits;
  logic signed [C2_W-1:0]   c2_nxt;
  logic signed [ACC_W-1:0]  p_acc, acc_start, acc_sum;
  logic signed [DRV_W-1:0]  sat_out;

  assign cur_tgt  = SAMPLE_BITS'(cfg.current_target);
  assign volt_tgt = SAMPLE_BITS'(cfg.voltage_target);
  assign end_cur  = SAMPLE_BITS'(cfg.end_current);

  assign stat.v_below = (v_r < volt_tgt);
  assign stat.i_above = (i_r > end_cur);

  assign kp_sel       = cmd.sel_volt ? cfg.voltage_gain_p : cfg.current_gain_p;
  assign ki_sel       = cmd.sel_volt ? cfg.voltage_gain_i : cfg.current_gain_i;
  assign tgt_sel      = cmd.sel_volt ? volt_tgt : cur_tgt;
  assign smp_sel      = cmd.sel_volt ? v_r : i_r;
  assign err_prev_sel = cmd.sel_volt ? volt_err_r : cur_err_r;
  assign out_prev_sel = cmd.sel_volt ? volt_out_r : cur_out_r;
  assign err_now      = $signed({1'b0, tgt_sel}) - $signed({1'b0, smp_sel});

  always_comb begin
    unique case (cmd.op)
      OP_KITS: begin
        mul_a = $signed({{(MUL_A_W-GAIN_W){1'b0}}, ki_sel});
        mul_b = $signed({{(MUL_B_W-TS_W){1'b0}}, cfg.sample_period});
      end
      OP_KP: begin
        mul_a = $signed({{(MUL_A_W-GAIN_W){1'b0}}, kp_sel});
        mul_b = {{(MUL_B_W-EW){err_now[EW-1]}}, err_now};
      end
      OP_KE: begin
        mul_a = c2_r;
        mul_b = {{(MUL_B_W-EW){err_prev_sel[EW-1]}}, err_prev_sel};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  // Ki*Ts rounded half up to Q4.12, then the error-old coefficient Ki*Ts - Kp
  assign kits_sum = p_r[KITS_W+TS_W-1:0] + KITS_RND;
  assign kits     = kits_sum[KITS_W+TS_W-1:TS_W];
  assign c2_nxt   = $signed({1'b0, kits}) - $signed({{(C2_W-GAIN_W){1'b0}}, kp_sel});

  assign p_acc     = p_r[ACC_W-1:0];
  assign acc_start = {{(ACC_W-DRV_W){out_prev_sel[DRV_W-1]}}, out_prev_sel} + p_acc;
  assign acc_sum   = acc_r + p_acc;

  always_comb begin
    priority if (acc_sum > SAT_MAX) sat_out = SAT_MAX[DRV_W-1:0];
    else if (acc_sum < SAT_MIN)     sat_out = SAT_MIN[DRV_W-1:0];
    else                            sat_out = acc_sum[DRV_W-1:0];
  end

  assign current_drive = cur_drive_r;
  assign voltage_drive = volt_drive_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      v_r <= SAMPLE_BITS'(in_voltage);
      i_r <= SAMPLE_BITS'(in_current);
    end
    if (cmd.op != OP_NONE) p_r <= product;
    if (cmd.op == OP_KP) c2_r <= c2_nxt;
    if (cmd.op == OP_KE) acc_r <= acc_start;
    if (cmd.out_load) begin
      cur_drive_r  <= cur_out_r;
      volt_drive_r <= volt_out_r;
    end
  end

  // loop state persists across charge cycles; only reset clears it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_out_r  <= '0;
      cur_err_r  <= '0;
      volt_out_r <= '0;
      volt_err_r <= '0;
    end else if (cmd.op == OP_FIN) begin
      if (cmd.sel_volt) begin
        volt_out_r <= sat_out;
        volt_err_r <= err_now;
      end else begin
        cur_out_r <= sat_out;
        cur_err_r <= err_now;
      end
    end
  end

endmodule

`default_nettype wire
